// ----- design/tlseq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlseq_pkg
// Shared types and constants for the two-road traffic light sequencer:
// phase codes, register map, run modes, manual colors and reset values.
// ----------------------------------------------------------------------------
package tlseq_pkg;

  // Cycle phases
  typedef enum logic [1:0] {
    PH_G1 = 2'd0,
    PH_Y1 = 2'd1,
    PH_G2 = 2'd2,
    PH_Y2 = 2'd3
  } phase_t;

  // Register map (index = byte address / 4)
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GREEN1   = 3'd0,
    REG_YELLOW1  = 3'd1,
    REG_GREEN2   = 3'd2,
    REG_YELLOW2  = 3'd3,
    REG_RUN_MODE = 3'd4,
    REG_MAN_COL  = 3'd5
  } reg_idx_t;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int TIME_W = 7;
  localparam int SECS_W = 8;
  localparam int MODE_W = 2;

  // Run modes; the unused code acts as manual hold
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

  // Manual colors; the unused code acts as all red
  localparam logic [MODE_W-1:0] COL_RED    = 2'd0;
  localparam logic [MODE_W-1:0] COL_GREEN  = 2'd1;
  localparam logic [MODE_W-1:0] COL_YELLOW = 2'd2;

  // Reset values
  localparam logic [TIME_W-1:0] RST_GREEN1  = 7'd25;
  localparam logic [TIME_W-1:0] RST_YELLOW1 = 7'd3;
  localparam logic [TIME_W-1:0] RST_GREEN2  = 7'd20;
  localparam logic [TIME_W-1:0] RST_YELLOW2 = 7'd3;

endpackage

// ----- design/two_road_traffic_light_sequencer.sv -----
// ----------------------------------------------------------------------------
// two_road_traffic_light_sequencer
// Four-phase two-road light sequencer with seconds countdown, flashing and
// manual modes, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// Result items are registered: each appears in the cycle after its tick item is accepted.
// Throughput: one item per cycle; the result register is refilled in the
//   same cycle it is drained, so only output backpressure stalls input.
// Reset (rst_n low, synchronous): phase road-one green, countdown, prescaler
//   and flash counter zero, registers to their defaults, no result pending.
module two_road_traffic_light_sequencer #(
  parameter int TICKS_PER_SECOND = 20,
  parameter int FLASH_PERIOD     = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_tick,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_road1_red,
  output logic                          out_road1_yellow,
  output logic                          out_road1_green,
  output logic                          out_road2_red,
  output logic                          out_road2_yellow,
  output logic                          out_road2_green,
  output logic [tlseq_pkg::SECS_W-1:0]  out_road1_seconds,
  output logic [tlseq_pkg::SECS_W-1:0]  out_road2_seconds,
  output logic                          out_display_blank,
  output logic [1:0]                    out_current_phase,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlseq_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlseq_pkg::DATA_W-1:0]  pwdata,
  output logic [tlseq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int SUB_W   = $clog2(TICKS_PER_SECOND);
  localparam int FLASH_W = $clog2(FLASH_PERIOD);
  localparam logic [SUB_W-1:0]   SUB_LAST   = SUB_W'(TICKS_PER_SECOND - 1);
  localparam logic [FLASH_W-1:0] FLASH_LAST = FLASH_W'(FLASH_PERIOD - 1);
  localparam logic [FLASH_W-1:0] FLASH_HALF = FLASH_W'(FLASH_PERIOD / 2);

  localparam int TW = tlseq_pkg::TIME_W;
  localparam int SW = tlseq_pkg::SECS_W;
  localparam int MW = tlseq_pkg::MODE_W;

  // Configuration registers
  logic [TW-1:0] green1_r, yellow1_r, green2_r, yellow2_r;
  logic [MW-1:0] run_mode_r, man_col_r;

  // Sequencer state
  tlseq_pkg::phase_t   phase_r, phase_nxt;
  logic [TW-1:0]       secs_r, secs_nxt;
  logic [SUB_W-1:0]    sub_r, sub_nxt;
  logic [FLASH_W-1:0]  flash_r, flash_nxt;

  // Result register
  logic          out_valid_r;
  logic [5:0]    lamps_r, lamps_nxt;   // {r1,y1,g1,r2,y2,g2}
  logic [SW-1:0] secs1_r, secs1_nxt, secs2_r, secs2_nxt;
  logic          blank_r, blank_nxt;
  logic [1:0]    cur_phase_r;

  logic                  accept;
  logic                  cfg_wr;
  tlseq_pkg::reg_idx_t   cfg_idx;
  logic                  manual, flashing;
  logic [SUB_W-1:0]      sub_inc;
  logic [TW-1:0]         secs_dec;
  tlseq_pkg::phase_t     phase_adv;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tlseq_pkg::reg_idx_t'(paddr[tlseq_pkg::ADDR_W-1:2]);

  assign manual   = run_mode_r[1];
  assign flashing = (run_mode_r == tlseq_pkg::MODE_FLASH);

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      tlseq_pkg::REG_GREEN1:   prdata = {{(tlseq_pkg::DATA_W-TW){1'b0}}, green1_r};
      tlseq_pkg::REG_YELLOW1:  prdata = {{(tlseq_pkg::DATA_W-TW){1'b0}}, yellow1_r};
      tlseq_pkg::REG_GREEN2:   prdata = {{(tlseq_pkg::DATA_W-TW){1'b0}}, green2_r};
      tlseq_pkg::REG_YELLOW2:  prdata = {{(tlseq_pkg::DATA_W-TW){1'b0}}, yellow2_r};
      tlseq_pkg::REG_RUN_MODE: prdata = {{(tlseq_pkg::DATA_W-MW){1'b0}}, run_mode_r};
      tlseq_pkg::REG_MAN_COL:  prdata = {{(tlseq_pkg::DATA_W-MW){1'b0}}, man_col_r};
      default:                 prdata = '0;
    endcase
  end

  // Next state for one tick
  always_comb begin
    sub_nxt   = sub_r;
    secs_nxt  = secs_r;
    phase_nxt = phase_r;
    flash_nxt = flash_r;
    sub_inc   = (sub_r == SUB_LAST) ? '0 : sub_r + SUB_W'(1);
    secs_dec  = (sub_inc == '0 && secs_r != '0) ? secs_r - TW'(1) : secs_r;
    phase_adv = tlseq_pkg::phase_t'(phase_r + 2'd1);
    if (in_tick) begin
      if (flashing) begin
        flash_nxt = (flash_r == FLASH_LAST) ? '0 : flash_r + FLASH_W'(1);
      end else if (!manual) begin
        sub_nxt  = sub_inc;
        secs_nxt = secs_dec;
        // countdown done: enter next phase and load its time
        if (secs_dec == '0) begin
          phase_nxt = phase_adv;
          unique case (phase_adv)
            tlseq_pkg::PH_G1: secs_nxt = green1_r;
            tlseq_pkg::PH_Y1: secs_nxt = yellow1_r;
            tlseq_pkg::PH_G2: secs_nxt = green2_r;
            tlseq_pkg::PH_Y2: secs_nxt = yellow2_r;
            default:          secs_nxt = green1_r;
          endcase
        end
      end
    end
  end

  // Lamps and display from the updated state
  always_comb begin
    lamps_nxt = 6'b000000;
    secs1_nxt = '0;
    secs2_nxt = '0;
    blank_nxt = 1'b1;
    if (manual) begin
      case (man_col_r)
        tlseq_pkg::COL_GREEN:  lamps_nxt = 6'b001001;
        tlseq_pkg::COL_YELLOW: lamps_nxt = 6'b010010;
        default:               lamps_nxt = 6'b100100;
      endcase
    end else if (flashing) begin
      lamps_nxt = (flash_nxt < FLASH_HALF) ? 6'b010010 : 6'b000000;
    end else begin
      blank_nxt = 1'b0;
      secs1_nxt = {1'b0, secs_nxt};
      secs2_nxt = {1'b0, secs_nxt};
      unique case (phase_nxt)
        tlseq_pkg::PH_G1: begin
          lamps_nxt = 6'b001100;
          secs2_nxt = SW'(secs_nxt) + SW'(yellow1_r);
        end
        tlseq_pkg::PH_Y1: lamps_nxt = 6'b010100;
        tlseq_pkg::PH_G2: begin
          lamps_nxt = 6'b100001;
          secs1_nxt = SW'(secs_nxt) + SW'(yellow2_r);
        end
        tlseq_pkg::PH_Y2: lamps_nxt = 6'b100010;
        default:          lamps_nxt = 6'b001100;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green1_r   <= tlseq_pkg::RST_GREEN1;
      yellow1_r  <= tlseq_pkg::RST_YELLOW1;
      green2_r   <= tlseq_pkg::RST_GREEN2;
      yellow2_r  <= tlseq_pkg::RST_YELLOW2;
      run_mode_r <= tlseq_pkg::MODE_NORMAL;
      man_col_r  <= tlseq_pkg::COL_RED;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tlseq_pkg::REG_GREEN1:   green1_r   <= pwdata[TW-1:0];
        tlseq_pkg::REG_YELLOW1:  yellow1_r  <= pwdata[TW-1:0];
        tlseq_pkg::REG_GREEN2:   green2_r   <= pwdata[TW-1:0];
        tlseq_pkg::REG_YELLOW2:  yellow2_r  <= pwdata[TW-1:0];
        tlseq_pkg::REG_RUN_MODE: run_mode_r <= pwdata[MW-1:0];
        tlseq_pkg::REG_MAN_COL:  man_col_r  <= pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state; a run mode write clears the flash counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlseq_pkg::PH_G1;
      secs_r  <= '0;
      sub_r   <= '0;
      flash_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        secs_r  <= secs_nxt;
        sub_r   <= sub_nxt;
        flash_r <= flash_nxt;
      end
      if (cfg_wr && cfg_idx == tlseq_pkg::REG_RUN_MODE) begin
        flash_r <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamps_r     <= lamps_nxt;
      secs1_r     <= secs1_nxt;
      secs2_r     <= secs2_nxt;
      blank_r     <= blank_nxt;
      cur_phase_r <= phase_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_road1_red     = lamps_r[5];
  assign out_road1_yellow  = lamps_r[4];
  assign out_road1_green   = lamps_r[3];
  assign out_road2_red     = lamps_r[2];
  assign out_road2_yellow  = lamps_r[1];
  assign out_road2_green   = lamps_r[0];
  assign out_road1_seconds = secs1_r;
  assign out_road2_seconds = secs2_r;
  assign out_display_blank = blank_r;
  assign out_current_phase = cur_phase_r;

endmodule
